@@ hw/rtl/prc_pkg.sv @@
package prc_pkg;

    // Defaults for the top-level parameters
    localparam int IterationsDef = 16;
    localparam int DataWidthDef  = 16;

    // Arctangent table depth; more iterations than this are capped
    localparam int TabLen = 24;

    // Internal datapath width for coordinates and Q30 angles
    localparam int InW = 36;

    // Coordinate fraction bits inside the datapath
    localparam int Frac = 16;

    // Angle limit at the output, pi in Q3.13
    localparam int AngleMax = 25736;

    typedef logic signed [InW-1:0] word_t;

    // CORDIC gain compensation 0.60725293500888 in Q30
    localparam logic [29:0] GainK = 30'd652032874;

    // pi and pi/2 in Q30
    localparam word_t PiQ30     = 36'sd3373259426;
    localparam word_t HalfPiQ30 = 36'sd1686629713;

    // Mode codes
    localparam logic ModeP2r = 1'b0;
    localparam logic ModeR2p = 1'b1;

    // Word carried through the rotation stages
    typedef struct packed {
        logic  mode;
        logic  flip;
        logic  zero;
        word_t x;
        word_t y;
        word_t z;
    } cordic_t;

    // atan(2^-idx) in Q30
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'h3243F6A8;
            1:       v = 30'h1DAC6705;
            2:       v = 30'h0FADBAFC;
            3:       v = 30'h07F56EA6;
            4:       v = 30'h03FEAB76;
            5:       v = 30'h01FFD55B;
            6:       v = 30'h00FFFAAA;
            7:       v = 30'h007FFF55;
            8:       v = 30'h003FFFEA;
            9:       v = 30'h001FFFFD;
            10:      v = 30'h000FFFFF;
            11:      v = 30'h0007FFFF;
            12:      v = 30'h0003FFFF;
            13:      v = 30'h0001FFFF;
            14:      v = 30'h0000FFFF;
            15:      v = 30'h00007FFF;
            16:      v = 30'h00003FFF;
            17:      v = 30'h00001FFF;
            18:      v = 30'h00000FFF;
            19:      v = 30'h000007FF;
            20:      v = 30'h000003FF;
            21:      v = 30'h000001FF;
            22:      v = 30'h000000FF;
            23:      v = 30'h0000007F;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/prc_prep.sv @@
module prc_prep
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [14:0]         radius_in,
    input  logic signed [15:0]  angle_in,
    input  logic signed [15:0]  x_in,
    input  logic signed [15:0]  y_in,
    output logic                out_valid,
    input  logic                out_ready,
    output prc_pkg::cordic_t    out_data
);

    // Stage A registers
    logic                a_valid_reg;
    logic                a_mode_reg;
    logic                a_flip_reg;
    logic                a_zero_reg;
    logic [44:0]         a_prod_reg;
    prc_pkg::word_t      a_x_reg;
    prc_pkg::word_t      a_y_reg;
    prc_pkg::word_t      a_z_reg;
    logic                a_ready;

    // Stage B registers
    logic                b_valid_reg;
    prc_pkg::cordic_t    b_data_reg;
    prc_pkg::cordic_t    b_data_next;

    // Stage A combinational values
    prc_pkg::word_t      z_raw;
    prc_pkg::word_t      z_rot;
    logic                flip;
    logic [44:0]         prod;
    prc_pkg::word_t      x_sh;
    prc_pkg::word_t      y_sh;
    prc_pkg::word_t      x_vec;
    prc_pkg::word_t      y_vec;
    prc_pkg::word_t      z_vec;
    logic                zero;
    logic [45:0]         prod_rnd;

    // Fold the rotation angle into the convergence range
    always_comb
    begin
        z_raw = prc_pkg::word_t'(angle_in) <<< 17;
        flip  = 1'b0;
        z_rot = z_raw;
        if (z_raw > prc_pkg::HalfPiQ30)
        begin
            z_rot = z_raw - prc_pkg::PiQ30;
            flip  = 1'b1;
        end
        else if (z_raw < -prc_pkg::HalfPiQ30)
        begin
            z_rot = z_raw + prc_pkg::PiQ30;
            flip  = 1'b1;
        end
    end

    // Scale the radius by the gain compensation
    assign prod = 45'(radius_in) * 45'(prc_pkg::GainK);

    // Mirror a vector with negative x into the right half plane
    always_comb
    begin
        x_sh  = prc_pkg::word_t'(x_in) <<< prc_pkg::Frac;
        y_sh  = prc_pkg::word_t'(y_in) <<< prc_pkg::Frac;
        zero  = (x_in == 16'sd0) && (y_in == 16'sd0);
        x_vec = x_sh;
        y_vec = y_sh;
        z_vec = '0;
        if (x_in[15])
        begin
            x_vec = -x_sh;
            y_vec = -y_sh;
            z_vec = y_in[15] ? -prc_pkg::PiQ30 : prc_pkg::PiQ30;
        end
    end

    assign in_ready = a_ready;
    assign a_ready  = ~a_valid_reg | ~b_valid_reg | out_ready;

    // Stage A valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    // Stage A payload
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_mode_reg <= mode;
            a_flip_reg <= (mode == prc_pkg::ModeP2r) ? flip : 1'b0;
            a_zero_reg <= (mode == prc_pkg::ModeR2p) ? zero : 1'b0;
            a_prod_reg <= prod;
            a_x_reg    <= x_vec;
            a_y_reg    <= y_vec;
            a_z_reg    <= (mode == prc_pkg::ModeP2r) ? z_rot : z_vec;
        end
    end

    // Round the scaled radius into the starting x
    assign prod_rnd = {1'b0, a_prod_reg} + 46'd8192;

    always_comb
    begin
        b_data_next.mode = a_mode_reg;
        b_data_next.flip = a_flip_reg;
        b_data_next.zero = a_zero_reg;
        b_data_next.z    = a_z_reg;
        if (a_mode_reg == prc_pkg::ModeP2r)
        begin
            b_data_next.x = prc_pkg::word_t'({4'd0, prod_rnd[45:14]});
            b_data_next.y = '0;
        end
        else
        begin
            b_data_next.x = a_x_reg;
            b_data_next.y = a_y_reg;
        end
    end

    // Stage B valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (~b_valid_reg | out_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage B payload
    always_ff @(posedge clk)
    begin
        if ((~b_valid_reg | out_ready) && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

@@ hw/rtl/prc_stage.sv @@
module prc_stage
#(
    parameter int STAGE = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  prc_pkg::cordic_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output prc_pkg::cordic_t  out_data
);

    localparam prc_pkg::word_t Atan =
        prc_pkg::word_t'({6'd0, prc_pkg::atan_q30(STAGE)});

    logic              valid_reg;
    prc_pkg::cordic_t  data_reg;
    prc_pkg::cordic_t  data_next;
    prc_pkg::word_t    dx;
    prc_pkg::word_t    dy;
    logic              pos;

    // One micro-rotation; direction from z in rotation mode, from y in vectoring
    always_comb
    begin
        dx  = in_data.x >>> STAGE;
        dy  = in_data.y >>> STAGE;
        pos = (in_data.mode == prc_pkg::ModeR2p) ? in_data.y[prc_pkg::InW-1]
                                                 : ~in_data.z[prc_pkg::InW-1];
        data_next = in_data;
        if (pos)
        begin
            data_next.x = in_data.x - dy;
            data_next.y = in_data.y + dx;
            data_next.z = in_data.z - Atan;
        end
        else
        begin
            data_next.x = in_data.x + dy;
            data_next.y = in_data.y - dx;
            data_next.z = in_data.z + Atan;
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    // Advance valid when the next stage has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold the word while stalled
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/prc_post.sv @@
module prc_post
#(
    parameter int DATA_WIDTH = prc_pkg::DataWidthDef
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  prc_pkg::cordic_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       out_data
);

    localparam prc_pkg::word_t CoordMax =
        prc_pkg::word_t'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic [39:0] RadiusMax = 40'((64'd1 << DATA_WIDTH) - 64'd1);
    localparam prc_pkg::word_t AngleLim = prc_pkg::word_t'(prc_pkg::AngleMax);

    // Stage C registers
    logic              c_valid_reg;
    logic              c_mode_reg;
    logic              c_zero_reg;
    prc_pkg::word_t    c_x_reg;
    prc_pkg::word_t    c_y_reg;
    prc_pkg::word_t    c_z_reg;
    logic [46:0]       c_pl_reg;
    logic [48:0]       c_ph_reg;
    logic              c_ready;

    // Output register
    logic              d_valid_reg;
    logic [63:0]       d_data_reg;
    logic [63:0]       d_data_next;

    // Stage D combinational values
    prc_pkg::word_t    x_sum;
    prc_pkg::word_t    y_sum;
    prc_pkg::word_t    x_rnd;
    prc_pkg::word_t    y_rnd;
    prc_pkg::word_t    x_sat;
    prc_pkg::word_t    y_sat;
    logic [65:0]       r_sum;
    logic [39:0]       r_rnd;
    logic [39:0]       r_sat;
    prc_pkg::word_t    z_sum;
    prc_pkg::word_t    a_rnd;
    prc_pkg::word_t    a_sat;

    assign c_ready  = ~c_valid_reg | ~d_valid_reg | out_ready;
    assign in_ready = c_ready;

    // Stage C valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= in_valid;
        end
    end

    // Undo the quadrant fold and split the radius product in two halves
    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_mode_reg <= in_data.mode;
            c_zero_reg <= in_data.zero;
            c_x_reg    <= in_data.flip ? -in_data.x : in_data.x;
            c_y_reg    <= in_data.flip ? -in_data.y : in_data.y;
            c_z_reg    <= in_data.z;
            c_pl_reg   <= 47'(in_data.x[16:0]) * 47'(prc_pkg::GainK);
            c_ph_reg   <= 49'(in_data.x[prc_pkg::InW-1:17]) * 49'(prc_pkg::GainK);
        end
    end

    // Round and saturate the rectangular results
    always_comb
    begin
        x_sum = c_x_reg + prc_pkg::word_t'(1 << (prc_pkg::Frac - 1));
        y_sum = c_y_reg + prc_pkg::word_t'(1 << (prc_pkg::Frac - 1));
        x_rnd = x_sum >>> prc_pkg::Frac;
        y_rnd = y_sum >>> prc_pkg::Frac;
        x_sat = x_rnd;
        y_sat = y_rnd;
        if (x_rnd > CoordMax)
        begin
            x_sat = CoordMax;
        end
        else if (x_rnd < -CoordMax)
        begin
            x_sat = -CoordMax;
        end
        if (y_rnd > CoordMax)
        begin
            y_sat = CoordMax;
        end
        else if (y_rnd < -CoordMax)
        begin
            y_sat = -CoordMax;
        end
    end

    // Recombine the radius product, round off 46 bits and saturate
    always_comb
    begin
        r_sum = {c_ph_reg, 17'd0} + {19'd0, c_pl_reg} + (66'd1 << 45);
        r_rnd = {20'd0, r_sum[65:46]};
        r_sat = (r_rnd > RadiusMax) ? RadiusMax : r_rnd;
    end

    // Round Q30 angle to Q3.13 and saturate at pi
    always_comb
    begin
        z_sum = c_z_reg + prc_pkg::word_t'(1 << 16);
        a_rnd = z_sum >>> 17;
        a_sat = a_rnd;
        if (a_rnd > AngleLim)
        begin
            a_sat = AngleLim;
        end
        else if (a_rnd < -AngleLim)
        begin
            a_sat = -AngleLim;
        end
    end

    // Zero the fields the mode does not produce, and all fields for a zero input vector
    always_comb
    begin
        d_data_next = '0;
        if (c_mode_reg == prc_pkg::ModeP2r)
        begin
            d_data_next[15:0]  = x_sat[15:0];
            d_data_next[31:16] = y_sat[15:0];
        end
        else if (!c_zero_reg)
        begin
            d_data_next[47:32] = r_sat[15:0];
            d_data_next[63:48] = a_sat[15:0];
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (~d_valid_reg | out_ready)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    // Output word, held while the receiver stalls
    always_ff @(posedge clk)
    begin
        if ((~d_valid_reg | out_ready) && c_valid_reg)
        begin
            d_data_reg <= d_data_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

@@ hw/rtl/polar_rect_converter_top.sv @@
// Polar/rectangular converter built on a pipelined CORDIC.
//
// Input stream: s_axis_tuser selects the direction (0 = polar to rectangular,
// 1 = rectangular to polar); s_axis_tdata carries radius, angle, x and y.
// Output stream: one word per input word, in order, on m_axis_tdata.
// Angles are radians in signed Q3.13; coordinates are 16-bit integers.
//
// Words pass through input scaling and quadrant folding (stages A and B),
// the micro-rotation stages, the gain multiply (stage C) and the output
// register. Throughput is one word per cycle while m_axis_tready is high;
// every stage is a register slice with its own valid bit.
//
// Reset clears all valid bits; the pipeline is empty and ready afterward.
// When m_axis_tready is low, words close up behind the output register and
// the input keeps accepting until every stage holds a word.
module polar_rect_converter_top
#(
    parameter int ITERATIONS = prc_pkg::IterationsDef,
    parameter int DATA_WIDTH = prc_pkg::DataWidthDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // radius_in[14:0], angle_in[30:15], x_in[46:31], y_in[62:47], zero fill[63]
    input  logic [63:0] s_axis_tdata,
    // mode[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // x_out[15:0], y_out[31:16], radius_out[47:32], angle_out[63:48]
    output logic [63:0] m_axis_tdata
);

    localparam int NStage = (ITERATIONS < prc_pkg::TabLen) ? ITERATIONS : prc_pkg::TabLen;

    prc_pkg::cordic_t  st  [0:NStage];
    logic              vld [0:NStage];
    logic              rdy [0:NStage];

    // Scale, fold and mirror the input
    prc_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .mode      (s_axis_tuser),
        .radius_in (s_axis_tdata[14:0]),
        .angle_in  (s_axis_tdata[30:15]),
        .x_in      (s_axis_tdata[46:31]),
        .y_in      (s_axis_tdata[62:47]),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_data  (st[0])
    );

    // One micro-rotation per stage
    for (genvar k = 0; k < NStage; k++)
    begin : g_stage
        prc_stage
        #(
            .STAGE (k)
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_data   (st[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_data  (st[k+1])
        );
    end

    // Gain, rounding, saturation and output register
    prc_post
    #(
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld[NStage]),
        .in_ready  (rdy[NStage]),
        .in_data   (st[NStage]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
